// ----- rtl/core/dhcpop_pkg.sv -----
// Shared types and constants for the DHCP request option parser.
package dhcpop_pkg;

  localparam logic [7:0] CookieB0   = 8'h63;
  localparam logic [7:0] CookieB1   = 8'h82;
  localparam logic [7:0] CookieB2   = 8'h53;
  localparam logic [7:0] CookieB3   = 8'h63;
  localparam logic [7:0] HwEthernet = 8'd1;
  localparam logic [7:0] HwMacLen   = 8'd6;
  localparam logic [7:0] TagPad     = 8'd0;
  localparam logic [7:0] TagEnd     = 8'd255;
  localparam logic [7:0] TagMsgType = 8'd53;
  localparam logic [7:0] TagReqIp   = 8'd50;
  localparam logic [7:0] TagSrvId   = 8'd54;
  localparam logic [7:0] LenMsgType = 8'd1;
  localparam logic [7:0] LenAddr    = 8'd4;

  localparam logic [7:0] MsgDiscover = 8'd1;
  localparam logic [7:0] MsgRequest  = 8'd3;
  localparam logic [7:0] MsgDecline  = 8'd4;
  localparam logic [7:0] MsgRelease  = 8'd7;
  localparam logic [7:0] MsgInform   = 8'd8;

  localparam int unsigned OutDataW = 80;

  typedef enum logic [3:0] {
    VerdictDiscover  = 4'd0,
    VerdictReqOurs   = 4'd1,
    VerdictReqOther  = 4'd2,
    VerdictRelOurs   = 4'd3,
    VerdictRelOther  = 4'd4,
    VerdictInform    = 4'd5,
    VerdictDecline   = 4'd6,
    VerdictUnknown   = 4'd7,
    VerdictBadLen    = 4'd8,
    VerdictBadHwType = 4'd9,
    VerdictBadHwLen  = 4'd10,
    VerdictNoEnd     = 4'd11
  } verdict_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       hw_type_bad;
    logic       hw_len_bad;
    logic [3:0] cookie_hit;
    logic       is_end;
    logic       is_pad;
    logic       is_msg_type;
    logic       is_req_ip;
    logic       is_srv_id;
    logic       len_one;
    logic       len_four;
    logic       len_zero;
  } byte_info_t;

endpackage

// ----- rtl/core/dhcpop_front.sv -----
// Input byte classifier: decodes tag, length, cookie and header checks.
module dhcpop_front import dhcpop_pkg::*; (
  input  logic [7:0]  option_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  hw_type_i,
  input  logic [7:0]  hw_len_i,
  output byte_info_t  info_o
);

  always_comb begin
    info_o.data          = option_byte_i;
    info_o.first         = first_byte_i;
    info_o.last          = last_byte_i;
    info_o.hw_type_bad   = (hw_type_i != HwEthernet);
    info_o.hw_len_bad    = (hw_len_i != HwMacLen);
    info_o.cookie_hit[0] = (option_byte_i == CookieB0);
    info_o.cookie_hit[1] = (option_byte_i == CookieB1);
    info_o.cookie_hit[2] = (option_byte_i == CookieB2);
    info_o.cookie_hit[3] = (option_byte_i == CookieB3);
    info_o.is_end        = (option_byte_i == TagEnd);
    info_o.is_pad        = (option_byte_i == TagPad);
    info_o.is_msg_type   = (option_byte_i == TagMsgType);
    info_o.is_req_ip     = (option_byte_i == TagReqIp);
    info_o.is_srv_id     = (option_byte_i == TagSrvId);
    info_o.len_one       = (option_byte_i == LenMsgType);
    info_o.len_four      = (option_byte_i == LenAddr);
    info_o.len_zero      = (option_byte_i == 8'd0);
  end

endmodule

// ----- rtl/core/dhcpop_queue.sv -----
// Two-entry queue of classified bytes between front and back.
module dhcpop_queue import dhcpop_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  byte_info_t  push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output byte_info_t  pop_data_o
);

  byte_info_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/dhcpop_back.sv -----
// Option walker: parse state, option capture and verdict output register.
module dhcpop_back import dhcpop_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         server_address_i,
  input  logic                item_valid_i,
  input  byte_info_t          item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  typedef enum logic [1:0] {
    PhCookie,
    PhTag,
    PhLen,
    PhValue
  } phase_e;

  typedef enum logic [1:0] {
    TagOther,
    TagIsMsg,
    TagIsIp,
    TagIsSrv
  } tag_kind_e;

  phase_e       phase_q, phase_d;
  tag_kind_e    tag_q, tag_d;
  logic [1:0]   cookie_cnt_q, cookie_cnt_d;
  logic         cookie_good_q, cookie_good_d;
  logic [7:0]   left_q, left_d;
  logic [7:0]   type_q, type_d;
  logic [31:0]  ip_q, ip_d;
  logic [31:0]  sid_q, sid_d;
  logic         done_q, done_d;
  logic         out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic         emit;
  verdict_e     verdict;
  verdict_e     class_verdict;
  logic         match;
  logic [7:0]   left_dec;

  assign item_pop_o  = item_valid_i && (!emit || !out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign left_dec    = left_q - 8'd1;

  always_comb begin
    unique case (type_q)
      MsgDiscover: class_verdict = VerdictDiscover;
      MsgRequest:  class_verdict = ((sid_q == server_address_i) || (sid_q == 32'd0)) ?
                                   VerdictReqOurs : VerdictReqOther;
      MsgRelease:  class_verdict = (sid_q == server_address_i) ?
                                   VerdictRelOurs : VerdictRelOther;
      MsgInform:   class_verdict = VerdictInform;
      MsgDecline:  class_verdict = VerdictDecline;
      default:     class_verdict = VerdictUnknown;
    endcase
  end

  always_comb begin
    phase_d       = phase_q;
    tag_d         = tag_q;
    cookie_cnt_d  = cookie_cnt_q;
    cookie_good_d = cookie_good_q;
    left_d        = left_q;
    type_d        = type_q;
    ip_d          = ip_q;
    sid_d         = sid_q;
    done_d        = done_q;
    emit          = 1'b0;
    verdict       = VerdictUnknown;
    match         = 1'b0;

    if (item_i.first) begin
      phase_d       = PhCookie;
      tag_d         = TagOther;
      cookie_cnt_d  = 2'd0;
      cookie_good_d = 1'b0;
      left_d        = 8'd0;
      type_d        = 8'd0;
      ip_d          = 32'd0;
      sid_d         = 32'd0;
      done_d        = 1'b0;
      if (item_i.hw_type_bad) begin
        emit    = 1'b1;
        verdict = VerdictBadHwType;
      end else if (item_i.hw_len_bad) begin
        emit    = 1'b1;
        verdict = VerdictBadHwLen;
      end
    end

    if (!emit && !done_d) begin
      unique case (phase_d)
        PhCookie: begin
          match         = item_i.cookie_hit[cookie_cnt_d];
          cookie_good_d = (cookie_cnt_d == 2'd0) ? match : (cookie_good_d && match);
          if (cookie_cnt_d == 2'd3) begin
            if (!cookie_good_d) begin
              emit    = 1'b1;
              verdict = VerdictUnknown;
            end else begin
              phase_d      = PhTag;
              cookie_cnt_d = 2'd0;
            end
          end else begin
            cookie_cnt_d = cookie_cnt_d + 2'd1;
          end
        end
        PhTag: begin
          if (item_i.is_end) begin
            emit    = 1'b1;
            verdict = class_verdict;
          end else if (!item_i.is_pad) begin
            phase_d = PhLen;
            if (item_i.is_msg_type) begin
              tag_d = TagIsMsg;
            end else if (item_i.is_req_ip) begin
              tag_d = TagIsIp;
            end else if (item_i.is_srv_id) begin
              tag_d = TagIsSrv;
            end else begin
              tag_d = TagOther;
            end
          end
        end
        PhLen: begin
          if (((tag_q == TagIsMsg) && !item_i.len_one) ||
              (((tag_q == TagIsIp) || (tag_q == TagIsSrv)) && !item_i.len_four)) begin
            emit    = 1'b1;
            verdict = VerdictBadLen;
          end else begin
            left_d  = item_i.data;
            phase_d = item_i.len_zero ? PhTag : PhValue;
          end
        end
        default: begin
          case (tag_q)
            TagIsMsg: type_d = item_i.data;
            TagIsIp:  ip_d   = {ip_q[23:0], item_i.data};
            TagIsSrv: sid_d  = {sid_q[23:0], item_i.data};
            default:  ;
          endcase
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = PhTag;
          end
        end
      endcase
      if (!emit && item_i.last) begin
        emit    = 1'b1;
        verdict = VerdictNoEnd;
      end
    end

    if (emit) begin
      done_d = 1'b1;
    end

    out_data_d = {4'd0, sid_d, ip_d, type_d, verdict};
    if (item_pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhCookie;
      tag_q         <= TagOther;
      cookie_cnt_q  <= 2'd0;
      cookie_good_q <= 1'b0;
      left_q        <= 8'd0;
      type_q        <= 8'd0;
      ip_q          <= 32'd0;
      sid_q         <= 32'd0;
      done_q        <= 1'b1;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (item_pop_o) begin
        phase_q       <= phase_d;
        tag_q         <= tag_d;
        cookie_cnt_q  <= cookie_cnt_d;
        cookie_good_q <= cookie_good_d;
        left_q        <= left_d;
        type_q        <= type_d;
        ip_q          <= ip_d;
        sid_q         <= sid_d;
        done_q        <= done_d;
        if (emit) begin
          out_data_q <= out_data_d;
        end
      end
    end
  end

endmodule

// ----- rtl/core/dhcp_request_option_parser_unit.sv -----
// Top level of the DHCP request option parser.
// Takes one options-area byte per cycle while the input queue has room and returns one verdict
// per packet, at the end option, at the first error, or with the last byte when no end option
// came. Each byte is classified on entry, held in a two-entry queue and walked by the option
// parser, so the sustained rate is one byte per clock unless a verdict waits; a verdict is
// captured in the output register after its byte passes the queue and the parse step, and
// waits there while further bytes that give no verdict keep flowing; a byte that gives the next
// verdict holds the parser until the waiting one is taken.
module dhcp_request_option_parser_unit import dhcpop_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,      // server_address
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,    // option_byte, hw_type, hw_len
  input  logic                s_axis_tuser,    // first_byte
  input  logic                s_axis_tlast,    // last_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata     // verdict, message_type, requested_ip,
                                               // server_id, 4 zero bits
);

  logic [31:0] server_address_q;
  byte_info_t  front_info;
  byte_info_t  queue_info;
  logic        queue_full;
  logic        queue_valid;
  logic        queue_pop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_address_q <= 32'd0;
    end else if (cfg_valid_i) begin
      server_address_q <= cfg_data_i;
    end
  end

  dhcpop_front u_front (
    .option_byte_i (s_axis_tdata[7:0]),
    .first_byte_i  (s_axis_tuser),
    .last_byte_i   (s_axis_tlast),
    .hw_type_i     (s_axis_tdata[15:8]),
    .hw_len_i      (s_axis_tdata[23:16]),
    .info_o        (front_info)
  );

  dhcpop_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_info),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_info)
  );

  dhcpop_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .server_address_i (server_address_q),
    .item_valid_i     (queue_valid),
    .item_i           (queue_info),
    .item_pop_o       (queue_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_o       (m_axis_tdata)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the DHCP request option parser: byte streams in, verdicts checked.
`timescale 1ns / 1ps

module testbench;
  import dhcpop_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned SqueezeCycles = 400;
  localparam int unsigned IdlePercent   = 24;

  typedef enum logic [1:0] {
    WalkCookie,
    WalkTag,
    WalkLen,
    WalkValue
  } walk_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] hw_type;
    logic [7:0] hw_len;
  } byte_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  msg_type;
    logic [31:0] req_ip;
    logic [31:0] server_id;
  } verdict_rec_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [31:0]         cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;   // option_byte, hw_type, hw_len
  logic                s_axis_tuser = 1'b0; // first_byte
  logic                s_axis_tlast = 1'b0; // last_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // verdict, message_type, requested_ip, server_id

  byte_item_t   tx_bytes[$];
  verdict_rec_t due_verdicts[$];
  logic [7:0]   pkt[$];

  logic [31:0] our_address = '0;
  walk_phase_e walk_phase = WalkCookie;
  logic [1:0]  cookie_idx = '0;
  logic        cookie_ok = 1'b0;
  logic [7:0]  opt_tag = '0;
  logic [7:0]  opt_left = '0;
  logic [7:0]  got_type = '0;
  logic [31:0] got_ip = '0;
  logic [31:0] got_server = '0;
  logic        pkt_closed = 1'b1;

  logic took_item = 1'b0;
  logic calm = 1'b0;
  logic squeeze_on = 1'b0;
  int   squeeze_count = 0;
  int   bad_count = 0;
  int   checked_count = 0;
  int   packet_count = 0;
  int   byte_count = 0;
  int   cfg_writes = 0;

  dhcp_request_option_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("** dhcp_request_option_parser_unit: FAILED **");
    $finish;
  end

  function automatic verdict_e classify();
    case (got_type)
      MsgDiscover: return VerdictDiscover;
      MsgRequest:  return (got_server == our_address || got_server == '0) ?
                          VerdictReqOurs : VerdictReqOther;
      MsgRelease:  return (got_server == our_address) ? VerdictRelOurs : VerdictRelOther;
      MsgInform:   return VerdictInform;
      MsgDecline:  return VerdictDecline;
      default:     return VerdictUnknown;
    endcase
  endfunction

  task automatic post_verdict(input verdict_e v);
    verdict_rec_t rec;
    rec.verdict   = v;
    rec.msg_type  = got_type;
    rec.req_ip    = got_ip;
    rec.server_id = got_server;
    due_verdicts.insert(due_verdicts.size(), rec);
    pkt_closed = 1'b1;
  endtask

  task automatic walk_byte(input byte_item_t it);
    logic [7:0] want;
    logic       hit;
    if (it.first) begin
      walk_phase = WalkCookie;
      cookie_idx = '0;
      cookie_ok  = 1'b0;
      opt_tag    = '0;
      opt_left   = '0;
      got_type   = '0;
      got_ip     = '0;
      got_server = '0;
      pkt_closed = 1'b0;
      if (it.hw_type != HwEthernet) begin
        post_verdict(VerdictBadHwType);
        return;
      end
      if (it.hw_len != HwMacLen) begin
        post_verdict(VerdictBadHwLen);
        return;
      end
    end
    if (pkt_closed) return;
    case (walk_phase)
      WalkCookie: begin
        case (cookie_idx)
          2'd0:    want = CookieB0;
          2'd1:    want = CookieB1;
          2'd2:    want = CookieB2;
          default: want = CookieB3;
        endcase
        hit = (it.data == want);
        cookie_ok = (cookie_idx == 2'd0) ? hit : (cookie_ok && hit);
        if (cookie_idx == 2'd3) begin
          if (!cookie_ok) begin
            post_verdict(VerdictUnknown);
            return;
          end
          walk_phase = WalkTag;
          cookie_idx = '0;
        end else begin
          cookie_idx = cookie_idx + 2'd1;
        end
      end
      WalkTag: begin
        if (it.data == TagEnd) begin
          post_verdict(classify());
          return;
        end
        if (it.data != TagPad) begin
          opt_tag = it.data;
          walk_phase = WalkLen;
        end
      end
      WalkLen: begin
        if ((opt_tag == TagMsgType && it.data != LenMsgType) ||
            ((opt_tag == TagReqIp || opt_tag == TagSrvId) && it.data != LenAddr)) begin
          post_verdict(VerdictBadLen);
          return;
        end
        opt_left = it.data;
        walk_phase = (it.data == 8'd0) ? WalkTag : WalkValue;
      end
      default: begin
        if (opt_tag == TagMsgType) got_type = it.data;
        else if (opt_tag == TagReqIp) got_ip = {got_ip[23:0], it.data};
        else if (opt_tag == TagSrvId) got_server = {got_server[23:0], it.data};
        opt_left = opt_left - 8'd1;
        if (opt_left == 8'd0) walk_phase = WalkTag;
      end
    endcase
    if (it.last) post_verdict(VerdictNoEnd);
  endtask

  task automatic check_result(input logic [OutDataW-1:0] d);
    verdict_rec_t rec;
    if (due_verdicts.size() == 0) begin
      bad_count++;
      if (bad_count <= 10) $display("%t unexpected verdict transfer: %h", $realtime, d);
      return;
    end
    rec = due_verdicts.pop_front();
    checked_count++;
    if (d[3:0] !== rec.verdict || d[11:4] !== rec.msg_type ||
        d[43:12] !== rec.req_ip || d[75:44] !== rec.server_id) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%t mismatch: want v=%0d t=%h ip=%h sid=%h, got v=%0d t=%h ip=%h sid=%h",
                 $realtime, rec.verdict, rec.msg_type, rec.req_ip, rec.server_id,
                 d[3:0], d[11:4], d[43:12], d[75:44]);
    end
  endtask

  always @(posedge clk_i) begin
    byte_item_t it;
    took_item <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      it = tx_bytes.pop_front();
      walk_byte(it);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // hold an offered byte until its transfer, then pick the next one or idle
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !took_item)) begin
      if (tx_bytes.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tx_bytes[0].hw_len, tx_bytes[0].hw_type, tx_bytes[0].data};
        s_axis_tuser  <= tx_bytes[0].first;
        s_axis_tlast  <= tx_bytes[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (squeeze_on && squeeze_count < SqueezeCycles) begin
      m_axis_tready <= 1'b0;
      squeeze_count <= squeeze_count + 1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  task automatic add_raw(input logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endtask

  task automatic add_cookie();
    pkt.delete();
    add_raw(CookieB0);
    add_raw(CookieB1);
    add_raw(CookieB2);
    add_raw(CookieB3);
  endtask

  task automatic add_type(input logic [7:0] t);
    add_raw(TagMsgType);
    add_raw(LenMsgType);
    add_raw(t);
  endtask

  task automatic add_addr(input logic [7:0] tag, input logic [31:0] a);
    add_raw(tag);
    add_raw(LenAddr);
    add_raw(a[31:24]);
    add_raw(a[23:16]);
    add_raw(a[15:8]);
    add_raw(a[7:0]);
  endtask

  task automatic ship(input logic [7:0] hwt, input logic [7:0] hwl, input bit with_last);
    byte_item_t it;
    foreach (pkt[i]) begin
      it.data    = pkt[i];
      it.first   = (i == 0);
      it.last    = with_last && (i == pkt.size() - 1);
      it.hw_type = (i == 0) ? hwt : 8'($urandom);
      it.hw_len  = (i == 0) ? hwl : 8'($urandom);
      tx_bytes.insert(tx_bytes.size(), it);
    end
    packet_count++;
    byte_count += pkt.size();
  endtask

  task automatic add_noise(input int n);
    byte_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data    = 8'($urandom);
      it.first   = 1'b0;
      it.last    = 1'($urandom);
      it.hw_type = 8'($urandom);
      it.hw_len  = 8'($urandom);
      tx_bytes.insert(tx_bytes.size(), it);
    end
  endtask

  task automatic make_random_packet();
    int          n_opts;
    int          len;
    logic [7:0]  hwt;
    logic [7:0]  hwl;
    logic [7:0]  t;
    logic [31:0] a;
    bit          with_last;
    add_cookie();
    if ($urandom_range(99) < 5) pkt[$urandom_range(3)] = 8'($urandom);
    n_opts = $urandom_range(5);
    for (int k = 0; k < n_opts; k++) begin
      case ($urandom_range(9))
        0: begin
          add_raw(TagPad);
          if ($urandom_range(1)) add_raw(TagPad);
        end
        1, 2, 3: begin
          case ($urandom_range(5))
            0: t = MsgDiscover;
            1: t = MsgRequest;
            2: t = MsgDecline;
            3: t = MsgRelease;
            4: t = MsgInform;
            default: t = 8'($urandom);
          endcase
          add_type(t);
        end
        4, 5: begin
          case ($urandom_range(2))
            0: a = our_address;
            1: a = '0;
            default: a = $urandom;
          endcase
          add_addr(TagSrvId, a);
        end
        6, 7: begin
          case ($urandom_range(3))
            0: a = '0;
            1: a = '1;
            default: a = $urandom;
          endcase
          add_addr(TagReqIp, a);
        end
        8: begin
          do t = 8'($urandom_range(1, 254));
          while (t == TagMsgType || t == TagReqIp || t == TagSrvId);
          len = $urandom_range(4);
          add_raw(t);
          add_raw(8'(len));
          for (int j = 0; j < len; j++) add_raw(8'($urandom));
        end
        default: begin
          if ($urandom_range(2) == 0) begin
            case ($urandom_range(2))
              0: add_raw(TagMsgType);
              1: add_raw(TagReqIp);
              default: add_raw(TagSrvId);
            endcase
            add_raw(8'($urandom));
          end else begin
            add_raw(TagPad);
          end
        end
      endcase
    end
    if ($urandom_range(99) < 10) begin
      while (pkt.size() > 1 && $urandom_range(3) != 0) void'(pkt.pop_back());
    end else if ($urandom_range(99) < 90) begin
      add_raw(TagEnd);
      for (int j = $urandom_range(2); j > 0; j--) add_raw(8'($urandom));
    end
    hwt = ($urandom_range(99) < 5) ? 8'($urandom) : HwEthernet;
    hwl = ($urandom_range(99) < 5) ? 8'($urandom) : HwMacLen;
    with_last = ($urandom_range(99) < 92);
    if ($urandom_range(7) == 0) add_noise($urandom_range(1, 3));
    ship(hwt, hwl, with_last);
  endtask

  task automatic random_traffic(input int target);
    int start;
    start = byte_count;
    while (byte_count - start < target) make_random_packet();
  endtask

  task automatic write_address(input logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    our_address = v;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (tx_bytes.size() != 0 || due_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_address(32'hC0A8_0001);
    pkt.delete();
    add_raw(CookieB0);
    ship(8'hFF, 8'hFF, 1'b1);
    pkt.delete();
    add_raw(CookieB0);
    ship(HwEthernet, 8'h00, 1'b1);
    pkt.delete();
    add_raw(CookieB0);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_noise(2);
    add_cookie();
    pkt[3] = 8'h62;
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgDiscover);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgRequest);
    add_addr(TagSrvId, 32'hC0A8_0001);
    add_addr(TagReqIp, 32'hFFFF_FFFF);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgRequest);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgRequest);
    add_addr(TagSrvId, 32'h0102_0304);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgRelease);
    add_addr(TagSrvId, 32'hC0A8_0001);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgRelease);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgRelease);
    add_type(MsgInform);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgDecline);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(8'hFF);
    add_addr(TagReqIp, 32'h0000_0000);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_raw(8'd12);
    add_raw(8'd0);
    add_raw(TagPad);
    add_raw(TagPad);
    add_type(MsgDiscover);
    add_raw(TagEnd);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_raw(TagMsgType);
    add_raw(8'd0);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_raw(TagReqIp);
    add_raw(8'd3);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_raw(TagSrvId);
    add_raw(8'hFF);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgDiscover);
    ship(HwEthernet, HwMacLen, 1'b1);
    add_cookie();
    add_type(MsgInform);
    ship(HwEthernet, HwMacLen, 1'b0);
    settle();

    write_address(32'h0000_0000);
    random_traffic(200);
    settle();

    // back-to-back traffic while the output is starved, so the input backs up
    write_address(32'hFFFF_FFFF);
    calm = 1'b1;
    random_traffic(200);
    squeeze_on = 1'b1;
    settle();
    calm = 1'b0;

    write_address($urandom);
    random_traffic(200);
    settle();

    $display("Sent %0d packets (%0d bytes) over %0d server address settings; %0d verdicts checked.",
             packet_count, byte_count, cfg_writes, checked_count);
    $display("Included header and cookie errors, bad lengths, missing end options, idle bytes,");
    $display("gapless traffic and a %0d-cycle output hold-off; %0d mismatches.",
             SqueezeCycles, bad_count);
    if (bad_count == 0) begin
      $display("** dhcp_request_option_parser_unit: PASSED **");
    end else begin
      $display("** dhcp_request_option_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
